/* sv/mrafq_pkg.sv */
// Shared types and constants for the MAC receive address filter queue.
// No dependencies; imported by mac_rx_address_filter_queue_unit.
package mrafq_pkg;

  localparam int QUEUE_SLOTS  = 5;
  localparam int MAX_PAYLOAD  = 64;
  localparam int HEADER_BYTES = 12;

  localparam int SLOT_W     = $clog2(QUEUE_SLOTS);
  localparam int LEN_W      = $clog2(MAX_PAYLOAD + 1);
  localparam int POS_W      = 8;
  localparam int PAY_DEPTH  = QUEUE_SLOTS * MAX_PAYLOAD;
  localparam int PAY_ADDR_W = $clog2(PAY_DEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Header byte positions where a field is complete
  localparam logic [POS_W-1:0] POS_TYPE_SEQ = POS_W'(3);
  localparam logic [POS_W-1:0] POS_SOURCE   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_DEST     = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_PAY_END  = POS_W'(HEADER_BYTES + MAX_PAYLOAD);

  typedef enum logic {
    CMD_RX_BYTE = 1'b0,
    CMD_POP     = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DELIVERED = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_DISABLED  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ADDR   = 2'd0,
    REG_BCAST_ADDR = 2'd1,
    REG_ENABLED    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_STREAM
  } pop_state_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       pkt_type;
    logic [15:0]      seq_number;
    logic [31:0]      source_address;
    logic [31:0]      dest_address;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       payload_byte;
    logic             last;
    logic [15:0]      overflow_count;
  } out_item_t;

  // One ring slot header
  typedef struct packed {
    logic [23:0]      type_seq;
    logic [31:0]      source;
    logic [31:0]      dest;
    logic [LEN_W-1:0] length;
  } slot_hdr_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
    logic [SLOT_W-1:0] r;
    if (i == SLOT_W'(QUEUE_SLOTS - 1)) r = '0;
    else r = i + SLOT_W'(1);
    return r;
  endfunction

endpackage

/* sv/mac_rx_address_filter_queue_unit.sv */
// Receive address filter with a packet ring, top level.
// Uses mrafq_pkg for item types, codes and sizes.
//
// Received frame bytes are taken one per cycle while no pop is in progress;
// header fields collect in registers and payload bytes go straight into the
// ring's payload memory. On the final byte the frame is filtered and its
// header is written into the slot header memory in one go. A pop reads the
// head slot header at its transfer; an empty, disabled or zero-length pop
// then loads its one result into the output register from the header state
// once that register is free. Otherwise the sequencer enters the stream
// state and issues payload reads into a registered read port; each read
// byte is loaded into the output register, one result per cycle while the
// output does not stall. Input is stalled until a pop's last result sits
// in the output register.
module mac_rx_address_filter_queue_unit
  import mrafq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration
  logic [31:0] own_addr_q, bcast_addr_q;
  logic        enabled_q;

  // Ring control and frame assembly
  pop_state_e        state_q, state_d;
  logic [SLOT_W-1:0] head_q, tail_q;
  logic [POS_W-1:0]  pos_q;
  logic [31:0]       shift_q;
  logic [23:0]       ts_q;
  logic [31:0]       src_q, dest_q;
  logic [15:0]       lost_q;
  status_e           pop_status_q;

  // Memories
  slot_hdr_t  hdr_mem [QUEUE_SLOTS];
  logic [7:0] pay_mem [PAY_DEPTH];
  slot_hdr_t  hdr_rd_q;
  logic [7:0] pay_rd_q;
  logic       rd_pend_q;
  logic [LEN_W-1:0] iss_idx_q, ld_idx_q;

  // Output register
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic in_acc, out_acc, out_free, rx, pop, fin;
  logic [31:0] shift_n, cur_dest;
  logic ring_full, size_ok, addr_ok, commit, pay_we;
  logic [PAY_ADDR_W-1:0] pay_waddr, pay_raddr;
  logic issue, load, head_adv, last_now;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || out_acc;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rx  = in_acc && (in_data_i.cmd == CMD_RX_BYTE);
  assign pop = in_acc && (in_data_i.cmd == CMD_POP);
  assign fin = in_data_i.last_byte;

  assign shift_n   = {shift_q[23:0], in_data_i.frame_byte};
  assign cur_dest  = (pos_q == POS_DEST) ? shift_n : dest_q;
  assign ring_full = (next_slot(tail_q) == head_q);
  // total length pos+1 within [HEADER_BYTES, HEADER_BYTES+MAX_PAYLOAD]
  assign size_ok   = (pos_q >= POS_DEST) && (pos_q < POS_PAY_END);
  assign addr_ok   = (cur_dest == own_addr_q) || (cur_dest == bcast_addr_q);
  assign commit    = rx && fin && !ring_full && size_ok && addr_ok;
  assign pay_we    = rx && (pos_q > POS_DEST) && (pos_q < POS_PAY_END);
  assign pay_waddr = PAY_ADDR_W'(32'(tail_q) * MAX_PAYLOAD)
                   + PAY_ADDR_W'(pos_q - POS_W'(HEADER_BYTES));
  assign pay_raddr = PAY_ADDR_W'(32'(head_q) * MAX_PAYLOAD) + PAY_ADDR_W'(iss_idx_q);
  assign last_now  = (ld_idx_q == hdr_rd_q.length - LEN_W'(1));

  // Pop sequencer: next state, output load and read issue
  always_comb begin
    state_d  = state_q;
    issue    = 1'b0;
    load     = 1'b0;
    head_adv = 1'b0;
    out_d    = out_q;
    case (state_q)
      ST_IDLE: begin
        if (pop) state_d = ST_HDR;
      end
      ST_HDR: begin
        if (pop_status_q != STAT_DELIVERED || hdr_rd_q.length == '0) begin
          if (out_free) begin
            load  = 1'b1;
            out_d = '0;
            out_d.status         = pop_status_q;
            out_d.last           = 1'b1;
            out_d.overflow_count = lost_q;
            if (pop_status_q == STAT_DELIVERED) begin
              out_d.pkt_type       = hdr_rd_q.type_seq[23:16];
              out_d.seq_number     = hdr_rd_q.type_seq[15:0];
              out_d.source_address = hdr_rd_q.source;
              out_d.dest_address   = hdr_rd_q.dest;
              head_adv             = 1'b1;
            end
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_STREAM;
        end
      end
      ST_STREAM: begin
        load  = rd_pend_q && out_free;
        issue = (iss_idx_q < hdr_rd_q.length) && (!rd_pend_q || load);
        if (load) begin
          out_d.status         = STAT_DELIVERED;
          out_d.pkt_type       = hdr_rd_q.type_seq[23:16];
          out_d.seq_number     = hdr_rd_q.type_seq[15:0];
          out_d.source_address = hdr_rd_q.source;
          out_d.dest_address   = hdr_rd_q.dest;
          out_d.payload_length = hdr_rd_q.length;
          out_d.payload_byte   = pay_rd_q;
          out_d.last           = last_now;
          out_d.overflow_count = lost_q;
          if (last_now) begin
            head_adv = 1'b1;
            state_d  = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   <= '0;
      bcast_addr_q <= '1;
      enabled_q    <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      pos_q        <= '0;
      shift_q      <= '0;
      lost_q       <= '0;
      pop_status_q <= STAT_EMPTY;
      rd_pend_q    <= 1'b0;
      iss_idx_q    <= '0;
      ld_idx_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_OWN_ADDR:   own_addr_q   <= cfg_data_i;
          REG_BCAST_ADDR: bcast_addr_q <= cfg_data_i;
          REG_ENABLED:    enabled_q    <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (rx) begin
        if (fin) begin
          pos_q   <= '0;
          shift_q <= '0;
          if (ring_full) begin
            if (lost_q != '1) lost_q <= lost_q + 16'd1;
          end else if (commit) begin
            tail_q <= next_slot(tail_q);
          end
        end else begin
          if (pos_q < POS_W'(HEADER_BYTES)) shift_q <= shift_n;
          if (pos_q != '1) pos_q <= pos_q + POS_W'(1);
        end
      end

      if (pop) begin
        if (!enabled_q)           pop_status_q <= STAT_DISABLED;
        else if (head_q == tail_q) pop_status_q <= STAT_EMPTY;
        else                       pop_status_q <= STAT_DELIVERED;
      end

      if (state_q == ST_HDR) begin
        iss_idx_q <= '0;
        ld_idx_q  <= '0;
      end else begin
        if (issue) iss_idx_q <= iss_idx_q + LEN_W'(1);
        if (load)  ld_idx_q  <= ld_idx_q + LEN_W'(1);
      end

      if (issue)     rd_pend_q <= 1'b1;
      else if (load) rd_pend_q <= 1'b0;

      if (head_adv) head_q <= next_slot(head_q);

      if (load)         out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  // Frame header fields and output payload
  always_ff @(posedge clk_i) begin
    if (rx) begin
      if (pos_q == POS_TYPE_SEQ) ts_q   <= {shift_n[31:24], shift_n[15:0]};
      if (pos_q == POS_SOURCE)   src_q  <= shift_n;
      if (pos_q == POS_DEST)     dest_q <= shift_n;
    end
    out_q <= out_d;
  end

  // Slot header memory: whole entry written on commit, read at pop transfer
  always_ff @(posedge clk_i) begin
    if (commit) begin
      hdr_mem[tail_q] <= '{type_seq: ts_q, source: src_q, dest: cur_dest,
                           length: LEN_W'(pos_q - POS_DEST)};
    end
    if (pop) hdr_rd_q <= hdr_mem[head_q];
  end

  // Payload memory: read data register holds while the output is stalled
  always_ff @(posedge clk_i) begin
    if (pay_we) pay_mem[pay_waddr] <= in_data_i.frame_byte;
    if (issue)  pay_rd_q <= pay_mem[pay_raddr];
  end

endmodule

/* sim/rx_queue_checker.sv */
// Scoreboard for the MAC receive address filter queue: watches the input,
// output and register channels, predicts every pop result and compares.
// Depends on mrafq_pkg for item types, codes and sizes.
module rx_queue_checker
  import mrafq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  // Shadow registers
  logic [31:0] own_addr;
  logic [31:0] bcast_addr;
  logic        pop_enable;

  // Shadow ring
  logic [23:0]      hdr_type_seq [QUEUE_SLOTS];
  logic [31:0]      hdr_src      [QUEUE_SLOTS];
  logic [31:0]      hdr_dst      [QUEUE_SLOTS];
  logic [LEN_W-1:0] hdr_len      [QUEUE_SLOTS];
  logic [7:0]       pay_mem      [PAY_DEPTH];
  logic [SLOT_W-1:0] ring_head;
  logic [SLOT_W-1:0] ring_tail;
  logic [POS_W-1:0]  rx_pos;
  logic [31:0]       rx_shift;
  logic [15:0]       drop_full_cnt;

  out_item_t delivery_q[$];

  function automatic logic [SLOT_W-1:0] ring_succ(input logic [SLOT_W-1:0] i);
    return (i == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count_o++;
    $display("mismatch %s: got %0h, want %0h (result %0d)", what, got, want, checked_o);
  endtask

  task automatic absorb_rx_byte(input logic [7:0] b, input logic fin);
    int unsigned       pos;
    int unsigned       total;
    logic [SLOT_W-1:0] t;
    pos = rx_pos;
    t   = ring_tail;
    if (pos < HEADER_BYTES) begin
      rx_shift = {rx_shift[23:0], b};
      if (rx_pos == '0) hdr_type_seq[t] = {b, 16'h0000};
      else if (rx_pos == POS_TYPE_SEQ) hdr_type_seq[t] = {hdr_type_seq[t][23:16], rx_shift[15:0]};
      else if (rx_pos == POS_SOURCE) hdr_src[t] = rx_shift;
      else if (rx_pos == POS_DEST) hdr_dst[t] = rx_shift;
    end else if (pos < HEADER_BYTES + MAX_PAYLOAD) begin
      pay_mem[int'(t) * MAX_PAYLOAD + pos - HEADER_BYTES] = b;
    end
    if (rx_pos != '1) rx_pos++;
    if (fin) begin
      total    = pos + 1;
      rx_pos   = '0;
      rx_shift = '0;
      // full ring wins over every other drop reason
      if (ring_succ(t) == ring_head) begin
        if (drop_full_cnt != 16'hFFFF) drop_full_cnt++;
      end else if (total >= HEADER_BYTES && total <= HEADER_BYTES + MAX_PAYLOAD &&
                   (hdr_dst[t] == own_addr || hdr_dst[t] == bcast_addr)) begin
        hdr_len[t] = LEN_W'(total - HEADER_BYTES);
        ring_tail  = ring_succ(t);
      end
    end
  endtask

  task automatic predict_pop();
    out_item_t         r;
    int unsigned       n;
    logic [SLOT_W-1:0] h;
    r = '0;
    r.overflow_count = drop_full_cnt;
    r.last = 1'b1;
    if (!pop_enable) begin
      r.status = STAT_DISABLED;
      delivery_q.push_back(r);
    end else if (ring_head == ring_tail) begin
      r.status = STAT_EMPTY;
      delivery_q.push_back(r);
    end else begin
      h = ring_head;
      r.status         = STAT_DELIVERED;
      r.pkt_type       = hdr_type_seq[h][23:16];
      r.seq_number     = hdr_type_seq[h][15:0];
      r.source_address = hdr_src[h];
      r.dest_address   = hdr_dst[h];
      r.payload_length = hdr_len[h];
      n = hdr_len[h];
      if (n == 0) begin
        delivery_q.push_back(r);
      end else begin
        for (int unsigned k = 0; k < n; k++) begin
          r.payload_byte = pay_mem[int'(h) * MAX_PAYLOAD + k];
          r.last         = (k == n - 1);
          delivery_q.push_back(r);
        end
      end
      ring_head = ring_succ(h);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (delivery_q.size() == 0) begin
      report_mismatch("unexpected result", 64'(got), 64'(0));
    end else begin
      want = delivery_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.pkt_type !== want.pkt_type)
        report_mismatch("pkt_type", 64'(got.pkt_type), 64'(want.pkt_type));
      if (got.seq_number !== want.seq_number)
        report_mismatch("seq_number", 64'(got.seq_number), 64'(want.seq_number));
      if (got.source_address !== want.source_address)
        report_mismatch("source_address", 64'(got.source_address), 64'(want.source_address));
      if (got.dest_address !== want.dest_address)
        report_mismatch("dest_address", 64'(got.dest_address), 64'(want.dest_address));
      if (got.payload_length !== want.payload_length)
        report_mismatch("payload_length", 64'(got.payload_length), 64'(want.payload_length));
      if (got.payload_byte !== want.payload_byte)
        report_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
      if (got.last !== want.last)
        report_mismatch("last", 64'(got.last), 64'(want.last));
      if (got.overflow_count !== want.overflow_count)
        report_mismatch("overflow_count", 64'(got.overflow_count), 64'(want.overflow_count));
      checked_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      own_addr      = '0;
      bcast_addr    = '1;
      pop_enable    = 1'b0;
      ring_head     = '0;
      ring_tail     = '0;
      rx_pos        = '0;
      rx_shift      = '0;
      drop_full_cnt = '0;
      delivery_q.delete();
      fail_count_o  = 0;
      checked_o     = 0;
    end else begin
      // results leave before a new transfer is predicted
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.cmd == CMD_POP) predict_pop();
        else absorb_rx_byte(in_data_i.frame_byte, in_data_i.last_byte);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_OWN_ADDR:   own_addr   = cfg_data_i[31:0];
          REG_BCAST_ADDR: bcast_addr = cfg_data_i[31:0];
          REG_ENABLED:    pop_enable = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    pending_o = delivery_q.size();
  end

endmodule

/* sim/tb_mac_rx_address_filter_queue_unit.sv */
// Testbench top for mac_rx_address_filter_queue_unit: clock, reset, frame and
// pop stimulus, register writes and verdict. Depends on mrafq_pkg and
// rx_queue_checker, which does all prediction and comparison.
module tb_mac_rx_address_filter_queue_unit
  import mrafq_pkg::*;
;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int QUIET_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int LOST_FRAMES  = 6;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int expected_left;
  int results_checked;
  int items_sent;
  int pops_sent;
  int frames_sent;
  int cycle_count;
  bit gaps_on;
  bit stall_on;
  bit hold_req;
  logic [31:0] cur_own;
  logic [31:0] cur_bcast;

  mac_rx_address_filter_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  rx_queue_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (expected_left),
    .checked_o    (results_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, expected_left);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= stall_on && ($urandom_range(99) < 30);
      end
    end
  end

  task automatic push_item(input in_item_t item);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    items_sent++;
  endtask

  task automatic push_pop();
    in_item_t it;
    it.cmd        = CMD_POP;
    it.frame_byte = 8'($urandom);
    it.last_byte  = 1'($urandom);
    pops_sent++;
    push_item(it);
  endtask

  function automatic logic [95:0] rand_header(input logic [31:0] dst);
    return {8'($urandom), 8'($urandom), 16'($urandom), 32'($urandom), dst};
  endfunction

  // Sends one frame; optionally slips a pop in somewhere inside it
  task automatic send_frame(input int unsigned n_bytes, input logic [95:0] hdr,
                            input bit pop_inside);
    in_item_t    it;
    int unsigned mid;
    mid = pop_inside ? $urandom_range(n_bytes - 1) : n_bytes;
    frames_sent++;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if (i == mid) push_pop();
      it.cmd        = CMD_RX_BYTE;
      it.frame_byte = (i < HEADER_BYTES) ? hdr[95 - 8 * i -: 8] : 8'($urandom);
      it.last_byte  = (i == n_bytes - 1);
      push_item(it);
    end
  endtask

  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 68) return HEADER_BYTES + $urandom_range(6);
    else if (roll < 78) return HEADER_BYTES + $urandom_range(MAX_PAYLOAD, 7);
    else if (roll < 88) return $urandom_range(HEADER_BYTES - 1, 1);
    else if (roll < 94) return HEADER_BYTES + MAX_PAYLOAD + $urandom_range(12, 1);
    else return HEADER_BYTES + ($urandom_range(1) ? MAX_PAYLOAD : 0);
  endfunction

  function automatic logic [31:0] pick_dest();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return cur_own;
    else if (roll < 80) return cur_bcast;
    else return $urandom;
  endfunction

  task automatic run_phase(input int unsigned n_items);
    int unsigned stop;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 35) push_pop();
      else send_frame(pick_length(), rand_header(pick_dest()), $urandom_range(99) < 8);
    end
  endtask

  task automatic set_cfg(input logic [31:0] own, input logic [31:0] bcast, input logic en);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_OWN_ADDR;
    cfg_data_i  <= own;
    @(negedge clk_i);
    cfg_index_i <= REG_BCAST_ADDR;
    cfg_data_i  <= bcast;
    @(negedge clk_i);
    cfg_index_i <= REG_ENABLED;
    cfg_data_i  <= {31'($urandom), en};
    @(negedge clk_i);
    cfg_index_i <= REG_SPARE;
    cfg_data_i  <= $urandom;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_own   = own;
    cur_bcast = bcast;
  endtask

  // Drop valid, wait out all results plus the receive pipeline
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_left != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    in_item_t it;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_OWN_ADDR;
    cfg_data_i  = '0;
    gaps_on     = 1'b1;
    stall_on    = 1'b1;
    hold_req    = 1'b0;
    cur_own     = '0;
    cur_bcast   = '1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: pops report disabled, frames are still filtered
    push_pop();
    push_pop();
    send_frame(HEADER_BYTES, {8'hFF, 8'h00, 16'hFFFF, 32'h0000_0000, 32'h0000_0000}, 0);
    send_frame(HEADER_BYTES + 3, {8'h00, 8'hFF, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0);
    settle();
    set_cfg(32'($urandom), 32'hFFFF_FFFF, 1'b1);
    push_pop();  // header-only packet
    push_pop();
    push_pop();  // ring empty now
    run_phase(30);

    // size limits, foreign destination
    send_frame(HEADER_BYTES - 1, rand_header(cur_bcast), 0);
    send_frame(HEADER_BYTES + MAX_PAYLOAD + 1, rand_header(cur_bcast), 1);
    send_frame(HEADER_BYTES + 2, rand_header(~cur_own), 0);
    repeat (5) push_pop();

    settle();
    set_cfg(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    // back-pressure: fill the ring, then hold the result side while popping
    repeat (5) push_pop();
    repeat (4) send_frame(HEADER_BYTES + $urandom_range(2), rand_header(cur_bcast), 0);
    hold_req = 1'b1;
    repeat (3) push_pop();
    repeat (2) send_frame(HEADER_BYTES + $urandom_range(2), rand_header(cur_own), 0);
    repeat (3) push_pop();
    run_phase(25);

    settle();
    set_cfg(32'h0000_0000, 32'($urandom), 1'b0);
    run_phase(25);

    settle();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    set_cfg(32'($urandom), 32'($urandom), 1'b1);
    run_phase(25);
    gaps_on  = 1'b1;
    stall_on = 1'b1;

    // full ring, then a few frames lost to it
    settle();
    repeat (5) push_pop();
    repeat (4) send_frame(HEADER_BYTES, rand_header(cur_bcast), 0);
    gaps_on = 1'b0;
    it.cmd       = CMD_RX_BYTE;
    it.last_byte = 1'b1;
    repeat (LOST_FRAMES) begin
      it.frame_byte = 8'($urandom);
      push_item(it);
    end
    gaps_on = 1'b1;
    repeat (2) push_pop();
    send_frame(HEADER_BYTES + 1, rand_header(cur_own), 0);
    repeat (4) push_pop();

    settle();
    repeat (20) @(posedge clk_i);
    $display("run: %0d transfers in, %0d pops, %0d frames, %0d one-byte frames into a full ring",
             items_sent, pops_sent, frames_sent + LOST_FRAMES, LOST_FRAMES);
    $display("run: %0d results checked over five register settings, %0d mismatches",
             results_checked, fail_count);
    if (fail_count == 0 && expected_left == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
